@@ hdl/sorted_id_handle_table_macros.svh @@
// Assertion macros for the sorted id/handle table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SORTED_ID_HANDLE_TABLE_MACROS_SVH
`define SORTED_ID_HANDLE_TABLE_MACROS_SVH

// a implies c in the same cycle
`define SIH_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// a implies c in the next cycle
`define SIH_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

@@ hdl/sih_pkg.sv @@
// Shared types and constants for the sorted id/handle table.
// No dependencies.
package sih_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_HANDLE_BITS = 32;

  localparam int ID_W         = 8;
  localparam int IN_HANDLE_W  = 32;
  localparam int COUNT_OUT_W  = 5;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = 40;   // id + handle, already byte aligned
  localparam int OUT_DATA_W   = 40;   // handle + count, padded to bytes
  localparam int OUT_USER_W   = 3;

  localparam logic [ID_W-1:0] EMPTY_ID = 8'h00;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2,
    ST_MISS   = 2'd3
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic            ins_en;
    logic [ID_W-1:0] id;
  } sih_cmd_t;

  // handed from a cell to its upper neighbor
  typedef struct packed {
    logic            valid;
    logic            le;      // valid and id <= key
    logic            match;   // valid and id == key
    logic [ID_W-1:0] id;
  } sih_link_t;

endpackage

@@ hdl/sih_cell.sv @@
// One table slot: id, handle and valid flag, with shift-up on insert.
// Depends on sih_pkg.
module sih_cell #(
  parameter int HANDLE_BITS = sih_pkg::DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sih_pkg::sih_cmd_t      cmd,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  sih_pkg::sih_link_t     prev_link,
  input  logic [HANDLE_BITS-1:0] prev_handle,
  output sih_pkg::sih_link_t     link,
  output logic [HANDLE_BITS-1:0] handle,
  output logic                   hit,
  output logic [HANDLE_BITS-1:0] hit_handle
);
  import sih_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic                   le, match;

  assign le    = valid_r && (id_r <= cmd.id);
  assign match = valid_r && (id_r == cmd.id);

  // sorted ids make matches contiguous: first match is unique
  assign hit        = match && !prev_link.match;
  assign hit_handle = hit ? handle_r : '0;

  assign link   = '{valid: valid_r, le: le, match: match, id: id_r};
  assign handle = handle_r;

  always_comb begin
    valid_nxt  = valid_r;
    id_nxt     = id_r;
    handle_nxt = handle_r;
    if (cmd.ins_en && !le) begin
      if (prev_link.le) begin
        valid_nxt  = 1'b1;
        id_nxt     = cmd.id;
        handle_nxt = new_handle;
      end else begin
        valid_nxt  = prev_link.valid;
        id_nxt     = prev_link.id;
        handle_nxt = prev_handle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      id_r    <= EMPTY_ID;
    end else begin
      valid_r <= valid_nxt;
      id_r    <= id_nxt;
    end
    handle_r <= handle_nxt;
  end

endmodule

@@ hdl/sih_chain.sv @@
// Row of table cells with the lookup result gather.
// Depends on sih_pkg and sih_cell.
module sih_chain #(
  parameter int TABLE_DEPTH = sih_pkg::DEF_TABLE_DEPTH,
  parameter int HANDLE_BITS = sih_pkg::DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sih_pkg::sih_cmd_t      cmd,
  input  logic [HANDLE_BITS-1:0] new_handle,
  output logic                   hit_any,
  output logic [HANDLE_BITS-1:0] hit_handle
);
  import sih_pkg::*;

  sih_link_t              links   [TABLE_DEPTH+1];
  logic [HANDLE_BITS-1:0] handles [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] hits;
  logic [HANDLE_BITS-1:0] hit_handles [TABLE_DEPTH];

  // below cell 0: always "less or equal", so cell 0 takes a new entry
  assign links[0]   = '{valid: 1'b1, le: 1'b1, match: 1'b0, id: EMPTY_ID};
  assign handles[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sih_cell #(
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_handle  (new_handle),
      .prev_link   (links[i]),
      .prev_handle (handles[i]),
      .link        (links[i+1]),
      .handle      (handles[i+1]),
      .hit         (hits[i]),
      .hit_handle  (hit_handles[i])
    );
  end

  // top cell's outputs feed nothing above it
  logic unused_top;
  assign unused_top = links[TABLE_DEPTH].valid ^ (^handles[TABLE_DEPTH]);

  assign hit_any = |hits;

  always_comb begin
    hit_handle = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_handle = hit_handle | hit_handles[i];
    end
  end

endmodule

@@ hdl/sorted_id_handle_table.sv @@
// Sorted id/handle table, top level.
// Depends on sih_pkg, sih_chain and sorted_id_handle_table_macros.svh.
//
// Input requests: in_tuser is the opcode (0 insert, 1 lookup), in_tdata holds
// the service id and the handle. Each request yields one result request on
// the out_ channel with status, found, the matched handle and the entry count.
// Entries sit in a row of cells sorted by ascending id; an insert shifts the
// cells above the insert point up by one, a lookup compares all cells at once
// and takes the lowest matching one.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while out_tready is high; the cell row
// updates in the accepting cycle, so the next request sees the new table.
// A full table rejects inserts (status 1); id 0 is rejected on insert
// (status 2); a lookup miss gives status 3 with handle 0.
// Reset clears all valid flags and the count; the table is empty right after
// reset, no clearing pass.
// While out_tready is low with a result pending, in_tready drops and the
// pending result holds.
module sorted_id_handle_table #(
  parameter int TABLE_DEPTH = sih_pkg::DEF_TABLE_DEPTH,
  parameter int HANDLE_BITS = sih_pkg::DEF_HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] svc_id, [39:8] handle_in
  input  logic [sih_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] opcode
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] handle_out, [36:32] entry_count, [39:37] zero
  output logic [sih_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status, [2] found
  output logic [sih_pkg::OUT_USER_W-1:0] out_tuser
);
  import sih_pkg::*;
  `include "sorted_id_handle_table_macros.svh"

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [ID_W-1:0]        req_id;
  logic [IN_HANDLE_W-1:0] req_handle;
  logic                   req_op;
  logic                   in_req;
  logic                   full;
  sih_cmd_t               cmd;
  logic                   hit_any;
  logic [HANDLE_BITS-1:0] hit_handle;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   out_valid_r;
  status_t                status_r, status_nxt;
  logic                   found_r, found_nxt;
  logic [IN_HANDLE_W-1:0] handle_out_r, handle_out_nxt;
  logic [COUNT_OUT_W-1:0] count_out_r;

  assign req_id     = in_tdata[ID_W-1:0];
  assign req_handle = in_tdata[ID_W +: IN_HANDLE_W];
  assign req_op     = in_tuser;

  assign in_tready = !out_valid_r || out_tready;
  assign in_req    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));

  assign cmd.ins_en = in_req && (req_op == OP_INSERT) && !full && (req_id != EMPTY_ID);
  assign cmd.id     = req_id;

  sih_chain #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .new_handle (HANDLE_BITS'(req_handle)),
    .hit_any    (hit_any),
    .hit_handle (hit_handle)
  );

  always_comb begin
    count_nxt      = cmd.ins_en ? count_r + 1'b1 : count_r;
    found_nxt      = 1'b0;
    handle_out_nxt = '0;
    if (req_op == OP_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else if (req_id == EMPTY_ID) begin
        status_nxt = ST_BAD_ID;
      end else begin
        status_nxt = ST_OK;
      end
    end else if (hit_any) begin
      status_nxt     = ST_OK;
      found_nxt      = 1'b1;
      handle_out_nxt = IN_HANDLE_W'(hit_handle);
    end else begin
      status_nxt = ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_req) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_req) begin
      status_r     <= status_nxt;
      found_r      <= found_nxt;
      handle_out_r <= handle_out_nxt;
      count_out_r  <= COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - IN_HANDLE_W - COUNT_OUT_W){1'b0}},
                       count_out_r, handle_out_r};
  assign out_tuser  = {found_r, status_r};

  `SIH_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_DEPTH), "count past depth")
  `SIH_ASSERT_NXT(a_insert_count, cmd.ins_en, count_r == $past(count_r) + 1'b1, "insert lost")
  `SIH_ASSERT_NXT(a_full_reject, in_req && (req_op == OP_INSERT) && full,
                  out_valid_r && (status_r == ST_FULL) && (count_r == $past(count_r)),
                  "full insert not rejected")
  `SIH_ASSERT_IMP(a_found_ok, out_valid_r && found_r, status_r == ST_OK, "found without ok")

endmodule

@@ tb/tb.sv @@
// Testbench for sorted_id_handle_table: inserts and lookups against an in-bench table model.
// Depends on sih_pkg and the sorted_id_handle_table RTL; stream handshakes with random idling.
`timescale 1ns / 100ps

module tb;
  import sih_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int N_RAND = 850;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic        op;
    logic [7:0]  id;
    logic [31:0] hnd;
    int          phase;
    bit          drain;
  } req_t;

  typedef struct {
    status_t     st;
    logic        hit;
    logic [31:0] hnd;
    logic [4:0]  cnt;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  req_t        req_q[$];
  resp_t       exp_resp_q[$];
  logic [7:0]  tbl_ids[DEPTH];
  logic [31:0] tbl_hnds[DEPTH];
  int          tbl_count = 0;

  logic [7:0]  gen_ids[$];
  int          gen_count = 0;

  int          phase = 0;
  int          snd_idle;
  int          rcv_idle;
  bit          took = 1'b0;
  int          cycles = 0;
  int          errors = 0;
  int          n_ins_ok = 0, n_full = 0, n_bad = 0, n_hit = 0, n_miss = 0;
  resp_t       want;
  resp_t       got;

  sorted_id_handle_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  assign snd_idle = (phase == 0) ? 7 : (phase == 1) ? 62 : 0;
  assign rcv_idle = (phase == 0) ? 62 : (phase == 1) ? 7 : 0;

  function automatic resp_t table_apply(input logic op, input logic [7:0] id,
                                        input logic [31:0] hnd);
    resp_t r;
    int    pos;
    r.st  = ST_MISS;
    r.hit = 1'b0;
    r.hnd = '0;
    if (op == OP_INSERT) begin
      if (tbl_count >= DEPTH) begin
        r.st = ST_FULL;
        n_full++;
      end else if (id == EMPTY_ID) begin
        r.st = ST_BAD_ID;
        n_bad++;
      end else begin
        pos = 0;
        while (pos < tbl_count && tbl_ids[pos] <= id) pos++;
        for (int k = tbl_count; k > pos; k--) begin
          tbl_ids[k]  = tbl_ids[k-1];
          tbl_hnds[k] = tbl_hnds[k-1];
        end
        tbl_ids[pos]  = id;
        tbl_hnds[pos] = hnd;
        tbl_count++;
        r.st = ST_OK;
        n_ins_ok++;
      end
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (!r.hit && tbl_ids[i] == id) begin
          r.st  = ST_OK;
          r.hit = 1'b1;
          r.hnd = tbl_hnds[i];
        end
      end
      if (r.hit) n_hit++;
      else n_miss++;
    end
    r.cnt = tbl_count[4:0];
    return r;
  endfunction

  task automatic add_req(input logic op, input logic [7:0] id, input logic [31:0] hnd,
                         input int ph, input bit drain);
    req_t r;
    r.op    = op;
    r.id    = id;
    r.hnd   = hnd;
    r.phase = ph;
    r.drain = drain;
    req_q.push_back(r);
    if (op == OP_INSERT && gen_count < DEPTH && id != EMPTY_ID) begin
      gen_ids.push_back(id);
      gen_count++;
    end
  endtask

  // driver: one request per handshake, inputs change on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
    if (rst_n && (!in_tvalid || took)) begin
      if (req_q.size() > 0 && !(req_q[0].drain && exp_resp_q.size() > 0) &&
          $urandom_range(99) >= snd_idle) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {req_q[0].hnd, req_q[0].id};
        in_tuser  <= req_q[0].op;
        phase     <= req_q[0].phase;
        void'(req_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and predictor on the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d requests pending, %0d results outstanding",
               $time, req_q.size(), exp_resp_q.size());
      $display("tb NOT OK");
      $finish;
    end else begin
      if (rst_n && out_tvalid && out_tready) begin
        got.st  = status_t'(out_tuser[1:0]);
        got.hit = out_tuser[2];
        got.hnd = out_tdata[31:0];
        got.cnt = out_tdata[36:32];
        if (exp_resp_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d found=%0d handle=%h count=%0d",
                   $time, got.st, got.hit, got.hnd, got.cnt);
          errors++;
        end else begin
          want = exp_resp_q.pop_front();
          if (got.st !== want.st) begin
            $display("%0t: status exp %0d got %0d", $time, want.st, got.st);
            errors++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: found exp %0d got %0d", $time, want.hit, got.hit);
            errors++;
          end
          if (got.hnd !== want.hnd) begin
            $display("%0t: handle exp %h got %h", $time, want.hnd, got.hnd);
            errors++;
          end
          if (got.cnt !== want.cnt) begin
            $display("%0t: count exp %0d got %0d", $time, want.cnt, got.cnt);
            errors++;
          end
        end
      end
      if (rst_n && in_tvalid && in_tready)
        exp_resp_q.push_back(table_apply(in_tuser, in_tdata[7:0], in_tdata[39:8]));
      took <= rst_n && in_tvalid && in_tready;
    end
  end

  initial begin
    int ph;
    int r;
    int idx;
    bit dr;

    // directed: empty lookup, bad id, extremes, duplicates, fill to full, then inserts and a lookup on the full table
    add_req(OP_LOOKUP, 8'd5, 32'h0, 0, 1'b0);
    add_req(OP_INSERT, EMPTY_ID, 32'h12345678, 0, 1'b0);
    add_req(OP_INSERT, 8'd255, 32'hffffffff, 0, 1'b0);
    add_req(OP_INSERT, 8'd1, 32'h00000000, 0, 1'b0);
    add_req(OP_INSERT, 8'd128, 32'ha5a5a5a5, 0, 1'b0);
    add_req(OP_INSERT, 8'd128, 32'h5a5a5a5a, 0, 1'b0);
    add_req(OP_LOOKUP, 8'd128, 32'hffffffff, 0, 1'b0);
    add_req(OP_INSERT, 8'd1, 32'hc3c3c3c3, 0, 1'b0);
    add_req(OP_LOOKUP, 8'd1, 32'h0, 0, 1'b0);
    add_req(OP_LOOKUP, EMPTY_ID, 32'h0, 0, 1'b0);
    add_req(OP_LOOKUP, 8'd255, 32'h0, 0, 1'b0);
    add_req(OP_INSERT, 8'd127, $urandom, 0, 1'b0);
    add_req(OP_INSERT, 8'd129, $urandom, 0, 1'b0);
    while (gen_count < DEPTH)
      add_req(OP_INSERT, 8'($urandom_range(1, 255)), $urandom, 0, 1'b0);
    add_req(OP_INSERT, EMPTY_ID, 32'hffffffff, 0, 1'b0);
    add_req(OP_INSERT, 8'd77, $urandom, 0, 1'b0);
    add_req(OP_LOOKUP, 8'd128, 32'h0, 0, 1'b0);

    // random: mostly lookups of stored ids, the rest random lookups and inserts
    for (int n = 0; n < N_RAND; n++) begin
      ph = n * 3 / N_RAND;
      r  = $urandom_range(99);
      dr = (n == 0 || n == 283 || n == 567 || n == 700);
      if (r < 55) begin
        idx = $urandom_range(gen_ids.size() - 1);
        add_req(OP_LOOKUP, gen_ids[idx], $urandom, ph, dr);
      end else if (r < 80) begin
        add_req(OP_LOOKUP, 8'($urandom_range(255)), $urandom, ph, dr);
      end else begin
        add_req(OP_INSERT, 8'($urandom_range(255)), $urandom, ph, dr);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_q.size() > 0 || in_tvalid) @(posedge clk);
    while (exp_resp_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("inserts ok %0d, full %0d, bad id %0d; lookups hit %0d, miss %0d",
             n_ins_ok, n_full, n_bad, n_hit, n_miss);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sih_pkg.sv
hdl/sih_cell.sv
hdl/sih_chain.sv
hdl/sorted_id_handle_table.sv
tb/tb.sv
